FILE: rtl/core/tgpi_pkg.sv
package tgpi_pkg;

  localparam int FRAC_BITS      = 8;
  localparam int MAX_AXIS_TILES = 1024;

  // Divider geometry: numerator magnitude and divisor width
  localparam int NUM_W  = 34;
  localparam int DEN_W  = 25;
  localparam int WIDE_W = 36;
  localparam int RA_W   = 26;
  localparam int PROD_W = 62;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [RA_W-1:0]   rem_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef enum logic [2:0] {
    CFG_SHAPE    = 3'd0,
    CFG_ORIGIN_X = 3'd1,
    CFG_ORIGIN_Y = 3'd2,
    CFG_TILE_W   = 3'd3,
    CFG_TILE_H   = 3'd4,
    CFG_COLUMNS  = 3'd5,
    CFG_ROWS     = 3'd6
  } cfg_idx_e;

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic               shape;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic [23:0]        tw;
    logic [23:0]        th;
    logic [10:0]        nc;
    logic [10:0]        nr;
  } cfg_t;

  // Item sideband that travels beside the dividers
  typedef struct packed {
    logic               op;
    logic               sx;
    logic               sy;
    logic               s2;
    logic signed [32:0] dx;
  } side_t;

  typedef struct packed {
    logic        col_valid;
    logic        row_valid;
    logic [9:0]  col_index;
    logic [9:0]  row_index;
    logic [19:0] linear_index;
  } res_t;

  function automatic logic [10:0] eff_count(logic [10:0] c);
    if (c == 11'd0) return 11'd1;
    if (32'(c) > MAX_AXIS_TILES) return 11'(MAX_AXIS_TILES);
    return c;
  endfunction

  function automatic wide_t clampw(wide_t v, wide_t lo, wide_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Triangle tests of the cell: {c1, c2, left, right}
  function automatic logic [3:0] tri_cmp(prod_t aa, prod_t bb, prod_t pp);
    logic c1, c2, lf, rt;
    c1 = bb < (pp - aa);
    c2 = bb < (aa - pp);
    lf = (bb - pp) > aa;
    rt = !lf && ((bb - pp) > ((pp <<< 1) - aa));
    return {c1, c2, lf, rt};
  endfunction

  // Staggered rhombus row; strict lookup answers -1 outside the grid
  function automatic wide_t rh_row(logic clamped, wide_t ix, wide_t iy, logic lt,
                                   logic gt, logic [3:0] cmp, wide_t nc, wide_t nr);
    wide_t r;
    wide_t idx;
    logic  edg;
    r = iy <<< 1;
    if (!clamped && (ix < 0 || ix > nc)) begin
      r = wide_t'(-1);
    end else if (lt) begin
      if (cmp[3]) begin
        if (ix == 0) begin
          if (!clamped) r = wide_t'(-1);
          else if (iy < 0) r = wide_t'(0);
          else if (iy >= nr) r = nr - 1;
          else r = iy <<< 1;
        end else if (iy == 0) begin
          r = clamped ? wide_t'(0) : wide_t'(-1);
        end else begin
          r = (iy <<< 1) - 1;
        end
      end else if (cmp[2]) begin
        if (iy == 0) r = clamped ? wide_t'(0) : wide_t'(-1);
        else r = (iy <<< 1) - 1;
      end
    end else if (gt) begin
      if (cmp[1] || cmp[0]) begin
        edg = cmp[1] ? (ix == 0) : (ix == nc);
        idx = (iy <<< 1) + 1;
        if (edg && !clamped) r = wide_t'(-1);
        else if (edg && iy < 0) r = wide_t'(0);
        else if (edg && iy >= nr) r = nr - 1;
        else if (idx >= nr) r = clamped ? nr - 1 : wide_t'(-1);
        else r = idx;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/tgpi_if.sv
interface tgpi_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  modport source (output valid, op, pos_x, pos_y, input ready);
  modport sink (input valid, op, pos_x, pos_y, output ready);
endinterface

interface tgpi_out_if;
  logic        valid;
  logic        ready;
  logic        col_valid;
  logic        row_valid;
  logic [9:0]  col_index;
  logic [9:0]  row_index;
  logic [19:0] linear_index;
  modport source (output valid, col_valid, row_valid, col_index, row_index, linear_index,
                  input ready);
  modport sink (input valid, col_valid, row_valid, col_index, row_index, linear_index,
                output ready);
endinterface

FILE: rtl/core/tgpi_div.sv
module tgpi_div import tgpi_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] num_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];

  // One restoring step per stage, most significant numerator bit first
  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W:0]   trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? DEN_W'(trial - {1'b0, den_i}) : DEN_W'(trial);
        num_q[k] <= num_in << 1;
        quo_q[k] <= {quo_in[NUM_W-2:0], fits};
      end
    end
  end

  assign quo_o = quo_q[NUM_W-1];
  assign rem_o = rem_q[NUM_W-1];

endmodule

FILE: rtl/core/tgpi_resolve.sv
module tgpi_resolve import tgpi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  side_t            side_i,
  input  cfg_t             cfg_i,
  input  logic [NUM_W-1:0] qx_i,
  input  logic [DEN_W-1:0] rx_i,
  input  logic [NUM_W-1:0] qy_i,
  input  logic [DEN_W-1:0] ry_i,
  input  logic [NUM_W-1:0] q2_i,
  output logic             valid_o,
  output res_t             res_o
);

  wide_t ncw, nrw;
  assign ncw = wide_t'({1'b0, cfg_i.nc});
  assign nrw = wide_t'({1'b0, cfg_i.nr});

  // Stage 1: sign the quotients and remainders
  logic  v1_q;
  logic  op1_q;
  wide_t ix1_q, iy1_q, q21_q, dx1_q, m1_q;
  rem_t  ra1_q, rb1_q;
  wide_t qxw, qyw, q2w, dxw;
  rem_t  rxw, ryw;

  assign qxw = wide_t'({2'b0, qx_i});
  assign qyw = wide_t'({2'b0, qy_i});
  assign q2w = wide_t'({2'b0, q2_i});
  assign rxw = rem_t'({1'b0, rx_i});
  assign ryw = rem_t'({1'b0, ry_i});
  assign dxw = wide_t'(side_i.dx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q <= side_i.op;
      ix1_q <= side_i.sx ? -qxw : qxw;
      iy1_q <= side_i.sy ? -qyw : qyw;
      q21_q <= side_i.s2 ? -q2w : q2w;
      ra1_q <= side_i.sx ? -rxw : rxw;
      rb1_q <= side_i.sy ? -ryw : ryw;
      dx1_q <= dxw;
      m1_q  <= wide_t'(WIDE_W'(cfg_i.nc - 11'd1) * WIDE_W'(cfg_i.tw));
    end
  end

  // Stage 2: clamp the cell column and pick the in-cell x offset
  logic  v2_q;
  logic  op2_q;
  wide_t ix2_q, ixc2_q, iy2_q, q22_q, ac2_q;
  rem_t  ra2_q, rb2_q;
  wide_t ixc_d, ac_d, raw1;

  assign raw1 = wide_t'(ra1_q);

  always_comb begin
    ixc_d = ix1_q;
    ac_d  = raw1;
    if (ix1_q < 0) begin
      ixc_d = '0;
      ac_d  = dx1_q;
    end else if (ix1_q > ncw) begin
      ixc_d = ncw - 1;
      ac_d  = dx1_q - m1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en_i) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op2_q  <= op1_q;
      ix2_q  <= ix1_q;
      ixc2_q <= ixc_d;
      iy2_q  <= iy1_q;
      q22_q  <= q21_q;
      ac2_q  <= ac_d;
      ra2_q  <= ra1_q;
      rb2_q  <= rb1_q;
    end
  end

  // Stage 3: cross products of the triangle tests
  logic  v3_q;
  logic  op3_q;
  wide_t ix3_q, ixc3_q, iy3_q, q23_q;
  prod_t as3_q, ac3_q, b3_q, p3_q;
  logic  lt3_q, gt3_q;
  prod_t twp, thp, rb2p;

  assign twp  = prod_t'({1'b0, cfg_i.tw});
  assign thp  = prod_t'({1'b0, cfg_i.th});
  assign rb2p = prod_t'(rb2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en_i) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op3_q  <= op2_q;
      ix3_q  <= ix2_q;
      ixc3_q <= ixc2_q;
      iy3_q  <= iy2_q;
      q23_q  <= q22_q;
      as3_q  <= (prod_t'(ra2_q) * thp) <<< 1;
      ac3_q  <= (prod_t'(ac2_q) * thp) <<< 1;
      b3_q   <= (rb2p * twp) <<< 1;
      p3_q   <= twp * thp;
      lt3_q  <= (rb2p <<< 1) < thp;
      gt3_q  <= (rb2p <<< 1) > thp;
    end
  end

  // Stage 4: row and column decision
  logic       v4_q;
  logic       cv4_q, rv4_q;
  logic [9:0] col4_q, row4_q;
  wide_t      srow, crow, row_d, col_d, rcl;
  logic [3:0] cmp_s, cmp_c;

  always_comb begin
    cmp_s = tri_cmp(as3_q, b3_q, p3_q);
    cmp_c = tri_cmp(ac3_q, b3_q, p3_q);
    srow  = rh_row(1'b0, ix3_q, iy3_q, lt3_q, gt3_q, cmp_s, ncw, nrw);
    crow  = rh_row(1'b1, ixc3_q, iy3_q, lt3_q, gt3_q, cmp_c, ncw, nrw);
    rcl   = clampw(srow, '0, nrw - 1);
    if (!cfg_i.shape) begin
      col_d = op3_q ? clampw(ix3_q, '0, ncw - 1) : ix3_q;
      row_d = op3_q ? clampw(iy3_q, '0, nrw - 1) : iy3_q;
    end else begin
      row_d = op3_q ? crow : srow;
      if (!op3_q && (srow < 0 || srow >= nrw)) begin
        col_d = wide_t'(-1);
      end else begin
        col_d = rcl[0] ? q23_q : ix3_q;
        if (op3_q) col_d = clampw(col_d, '0, ncw - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en_i) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cv4_q  <= (col_d >= 0) && (col_d < ncw);
      rv4_q  <= (row_d >= 0) && (row_d < nrw);
      col4_q <= ((col_d >= 0) && (col_d < ncw)) ? col_d[9:0] : '0;
      row4_q <= ((row_d >= 0) && (row_d < nrw)) ? row_d[9:0] : '0;
    end
  end

  // Stage 5: linear index
  logic  v5_q;
  res_t  res5_q;
  logic [20:0] lin_d;

  assign lin_d = 21'(row4_q) * 21'(cfg_i.nc) + 21'(col4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en_i) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res5_q.col_valid    <= cv4_q;
      res5_q.row_valid    <= rv4_q;
      res5_q.col_index    <= col4_q;
      res5_q.row_index    <= row4_q;
      res5_q.linear_index <= (cv4_q && rv4_q) ? lin_d[19:0] : '0;
    end
  end

  assign valid_o = v5_q;
  assign res_o   = res5_q;

endmodule

FILE: rtl/core/tgpi_ofifo.sv
module tgpi_ofifo import tgpi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  res_t  data_i,
  output logic  space_o,
  tgpi_out_if.source out_o
);

  res_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       pop;
  res_t       head;

  assign pop     = out_o.valid && out_o.ready;
  assign space_o = cnt_q != 2'd2;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  assign head                = mem_q[rptr_q];
  assign out_o.valid         = cnt_q != 2'd0;
  assign out_o.col_valid     = head.col_valid;
  assign out_o.row_valid     = head.row_valid;
  assign out_o.col_index     = head.col_index;
  assign out_o.row_index     = head.row_index;
  assign out_o.linear_index  = head.linear_index;

endmodule

FILE: rtl/core/tile_grid_position_to_index_core.sv
// Tile grid picking: maps a world position to a tile column, row and
// linear index of a rectangular or staggered rhombus grid.
// Input channel in_i carries op (strict or clamped lookup) and the signed
// fixed point position; output channel out_o carries the valid flags and
// the indices, one item out for every item in, in order.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// no item is in flight: the user must keep to this, the block does not
// enforce it. Unknown indexes are ignored. Throughput: one item per cycle
// while the output buffer has space. The input stage takes the item at the
// accepting edge; then the three 34-stage bit-per-stage dividers (x by tile
// width, y by tile height, half-offset x by twice the width), five resolve
// stages and the output buffer follow.
// Reset clears all valid bits and loads the default configuration: one
// 1.0 by 1.0 rectangular tile at the origin.
// When out_o stalls, a two-entry output buffer keeps taking results; once
// it is full the whole pipeline holds, and in_i.ready drops until the
// receiver takes an item. Nothing is dropped or repeated.
module tile_grid_position_to_index_core import tgpi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  tgpi_in_if.sink     in_i,
  tgpi_out_if.source  out_o
);

  // Configuration registers
  logic               shape_q;
  logic signed [31:0] ox_q, oy_q;
  logic [23:0]        tw_q, th_q;
  logic [10:0]        nc_q, nr_q;
  cfg_t               cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= 1'b0;
      ox_q    <= '0;
      oy_q    <= '0;
      tw_q    <= 24'(1 << FRAC_BITS);
      th_q    <= 24'(1 << FRAC_BITS);
      nc_q    <= 11'd1;
      nr_q    <= 11'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHAPE:    shape_q <= cfg_data_i[0];
        CFG_ORIGIN_X: ox_q    <= cfg_data_i;
        CFG_ORIGIN_Y: oy_q    <= cfg_data_i;
        CFG_TILE_W:   tw_q    <= cfg_data_i[23:0];
        CFG_TILE_H:   th_q    <= cfg_data_i[23:0];
        CFG_COLUMNS:  nc_q    <= cfg_data_i[10:0];
        CFG_ROWS:     nr_q    <= cfg_data_i[10:0];
        default:      ;
      endcase
    end
  end

  assign cfg.shape = shape_q;
  assign cfg.ox    = ox_q;
  assign cfg.oy    = oy_q;
  assign cfg.tw    = (tw_q == '0) ? 24'd1 : tw_q;
  assign cfg.th    = (th_q == '0) ? 24'd1 : th_q;
  assign cfg.nc    = eff_count(nc_q);
  assign cfg.nr    = eff_count(nr_q);

  logic en;
  assign in_i.ready = en;

  // Input stage: offsets from the origin
  logic               v0_q;
  logic               op0_q;
  logic signed [32:0] dx0_q, dy0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q <= in_i.op;
      dx0_q <= 33'(in_i.pos_x) - 33'(cfg.ox);
      dy0_q <= 33'(in_i.pos_y) - 33'(cfg.oy);
    end
  end

  // Split into sign and magnitude for the dividers
  logic signed [NUM_W:0] dxe, dye, n2e;
  logic [NUM_W-1:0]      magx, magy, mag2;
  side_t                 side0;

  assign dxe  = (NUM_W+1)'(dx0_q);
  assign dye  = (NUM_W+1)'(dy0_q);
  assign n2e  = (dxe <<< 1) - $signed({11'd0, cfg.tw});
  assign magx = dxe[NUM_W] ? NUM_W'(-dxe) : NUM_W'(dxe);
  assign magy = dye[NUM_W] ? NUM_W'(-dye) : NUM_W'(dye);
  assign mag2 = n2e[NUM_W] ? NUM_W'(-n2e) : NUM_W'(n2e);

  assign side0.op = op0_q;
  assign side0.sx = dxe[NUM_W];
  assign side0.sy = dye[NUM_W];
  assign side0.s2 = n2e[NUM_W];
  assign side0.dx = dx0_q;

  logic [NUM_W-1:0] qx, qy, q2;
  logic [DEN_W-1:0] rx, ry;

  tgpi_div u_div_x (
    .clk_i (clk_i), .en_i (en), .num_i (magx), .den_i ({1'b0, cfg.tw}),
    .quo_o (qx), .rem_o (rx)
  );

  tgpi_div u_div_y (
    .clk_i (clk_i), .en_i (en), .num_i (magy), .den_i ({1'b0, cfg.th}),
    .quo_o (qy), .rem_o (ry)
  );

  tgpi_div u_div_h (
    .clk_i (clk_i), .en_i (en), .num_i (mag2), .den_i ({cfg.tw, 1'b0}),
    .quo_o (q2), .rem_o ()
  );

  // Sideband line matching the divider depth
  logic  vs_q   [NUM_W];
  side_t side_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vs_q[k] <= 1'b0;
      else if (en) vs_q[k] <= (k == 0) ? v0_q : vs_q[(k == 0) ? 0 : k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) side_q[k] <= (k == 0) ? side0 : side_q[(k == 0) ? 0 : k-1];
    end
  end

  logic res_v;
  res_t res;

  tgpi_resolve u_resolve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vs_q[NUM_W-1]),
    .side_i  (side_q[NUM_W-1]),
    .cfg_i   (cfg),
    .qx_i    (qx),
    .rx_i    (rx),
    .qy_i    (qy),
    .ry_i    (ry),
    .q2_i    (q2),
    .valid_o (res_v),
    .res_o   (res)
  );

  tgpi_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en && res_v),
    .data_i  (res),
    .space_o (en),
    .out_o   (out_o)
  );

endmodule

FILE: tb/tb_tile_grid_position_to_index_core.sv
module tb_tile_grid_position_to_index_core;
  import tgpi_pkg::*;

  localparam int          PHASES     = 13;
  localparam int          PHASE_ITEMS = 148;
  localparam logic [2:0]  CFG_SPARE  = 3'd7;  // not a register, writes are dropped
  localparam logic        OP_STRICT  = 1'b0;
  localparam logic        OP_CLAMP   = 1'b1;
  localparam logic        SHAPE_RECT = 1'b0;
  localparam logic        SHAPE_RHOM = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CFG_SHAPE;
  logic [31:0] cfg_data_i = '0;

  tgpi_in_if  in_if ();
  tgpi_out_if out_if ();

  tile_grid_position_to_index_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the grid registers
  logic        grid_shape = SHAPE_RECT;
  logic [31:0] grid_ox = '0;
  logic [31:0] grid_oy = '0;
  logic [23:0] grid_tw = 24'd256;
  logic [23:0] grid_th = 24'd256;
  logic [10:0] grid_nc = 11'd1;
  logic [10:0] grid_nr = 11'd1;

  res_t tile_q[$];
  int   errors = 0;
  int   n_in = 0;
  int   n_out = 0;
  int   n_rhom = 0;
  logic cur_typed = 1'b0;
  res_t cur_typed_res = '0;

  typedef struct {
    logic        op;
    logic [31:0] x;
    logic [31:0] y;
    logic        typed;
    res_t        res;
  } probe_t;

  // Directed probes at the reset grid: one 1.0 x 1.0 rectangular tile at 0,0
  probe_t probes[] = '{
    '{OP_STRICT, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 1'b1, 10'd0, 10'd0, 20'd0}},
    '{OP_STRICT, 32'h0000_00FF, 32'h0000_00FF, 1'b1, '{1'b1, 1'b1, 10'd0, 10'd0, 20'd0}},
    '{OP_STRICT, 32'h0000_0100, 32'h0000_0000, 1'b1, '{1'b0, 1'b1, 10'd0, 10'd0, 20'd0}},
    '{OP_STRICT, 32'h0000_0000, 32'h0000_0100, 1'b1, '{1'b1, 1'b0, 10'd0, 10'd0, 20'd0}},
    '{OP_STRICT, 32'hFFFF_FF00, 32'hFFFF_FF00, 1'b1, '{1'b0, 1'b0, 10'd0, 10'd0, 20'd0}},
    '{OP_STRICT, 32'hFFFF_FF01, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b1, 10'd0, 10'd0, 20'd0}},
    '{OP_STRICT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, 1'b0, 10'd0, 10'd0, 20'd0}},
    '{OP_STRICT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b0, 10'd0, 10'd0, 20'd0}},
    '{OP_CLAMP,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b1, 1'b1, 10'd0, 10'd0, 20'd0}},
    '{OP_CLAMP,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b1, 1'b1, 10'd0, 10'd0, 20'd0}},
    '{OP_CLAMP,  32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 1'b1, 10'd0, 10'd0, 20'd0}},
    '{OP_CLAMP,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{OP_STRICT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{OP_CLAMP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_STRICT, 32'h0000_0080, 32'h0000_0080, 1'b0, '0}
  };

  function automatic longint axis_count(logic [10:0] c);
    if (c == 0) return 1;
    if (c > MAX_AXIS_TILES) return MAX_AXIS_TILES;
    return longint'(c);
  endfunction

  // Row of a staggered rhombus grid; strict lookup gives -1 off the grid
  function automatic longint stagger_row(longint dx, longint dy, longint tw, longint th,
                                         longint nc, longint nr, bit clamped);
    longint ix, iy, a, b, aa, bb, pp, idx;
    bit     lf, rt, edg;
    ix = dx / tw;
    iy = dy / th;
    if (clamped) begin
      if (ix < 0) ix = 0;
      else if (ix > nc) ix = nc - 1;
    end else if (ix < 0 || ix > nc) begin
      return -1;
    end
    a  = dx - ix * tw;
    b  = dy - iy * th;
    aa = 2 * a * th;
    bb = 2 * b * tw;
    pp = tw * th;
    if (2 * b < th) begin
      if (bb < pp - aa) begin
        if (ix == 0) begin
          if (!clamped) return -1;
          if (iy < 0) return 0;
          if (iy >= nr) return nr - 1;
          return iy * 2;
        end
        if (iy == 0) return clamped ? 0 : -1;
        return iy * 2 - 1;
      end
      if (bb < aa - pp) begin
        if (iy == 0) return clamped ? 0 : -1;
        return iy * 2 - 1;
      end
      return iy * 2;
    end
    if (2 * b > th) begin
      lf = (bb - pp > aa);
      rt = !lf && (bb - pp > 2 * pp - aa);
      if (lf || rt) begin
        edg = lf ? (ix == 0) : (ix == nc);
        if (edg) begin
          if (!clamped) return -1;
          if (iy < 0) return 0;
          if (iy >= nr) return nr - 1;
        end
        idx = iy * 2 + 1;
        if (idx >= nr) return clamped ? nr - 1 : -1;
        return idx;
      end
    end
    return iy * 2;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Expected tile of one query under the current grid
  function automatic res_t pick_tile(logic op, logic [31:0] px, logic [31:0] py);
    longint dx, dy, tw, th, nc, nr, col, row, srow, r;
    bit     cv, rv;
    res_t   o;
    dx = longint'($signed(px)) - longint'($signed(grid_ox));
    dy = longint'($signed(py)) - longint'($signed(grid_oy));
    tw = grid_tw == 0 ? 1 : longint'(grid_tw);
    th = grid_th == 0 ? 1 : longint'(grid_th);
    nc = axis_count(grid_nc);
    nr = axis_count(grid_nr);
    if (grid_shape == SHAPE_RECT) begin
      col = dx / tw;
      row = dy / th;
      if (op == OP_CLAMP) begin
        col = clip(col, 0, nc - 1);
        row = clip(row, 0, nr - 1);
      end
    end else begin
      srow = stagger_row(dx, dy, tw, th, nc, nr, 1'b0);
      row  = (op == OP_CLAMP) ? stagger_row(dx, dy, tw, th, nc, nr, 1'b1) : srow;
      if (op == OP_STRICT && (srow < 0 || srow >= nr)) begin
        col = -1;
      end else begin
        r = clip(srow, 0, nr - 1);
        col = (r % 2 == 0) ? dx / tw : (2 * dx - tw) / (2 * tw);
        if (op == OP_CLAMP) col = clip(col, 0, nc - 1);
      end
    end
    cv = col >= 0 && col < nc;
    rv = row >= 0 && row < nr;
    if (!cv) col = 0;
    if (!rv) row = 0;
    o.col_valid    = cv;
    o.row_valid    = rv;
    o.col_index    = col[9:0];
    o.row_index    = row[9:0];
    o.linear_index = (cv && rv) ? 20'(row * nc + col) : 20'd0;
    return o;
  endfunction

  // Record each accepted query, check each delivered tile
  always @(posedge clk_i) begin
    res_t want;
    if (in_if.valid && in_if.ready) begin
      tile_q.insert(tile_q.size(),
                    cur_typed ? cur_typed_res : pick_tile(in_if.op, in_if.pos_x, in_if.pos_y));
      n_in++;
      if (grid_shape == SHAPE_RHOM) n_rhom++;
    end
    if (out_if.valid && out_if.ready) begin
      n_out++;
      if (tile_q.size() == 0) begin
        $error("tile delivered with nothing pending");
        errors++;
      end else begin
        want = tile_q.pop_front();
        if (out_if.col_valid !== want.col_valid) begin
          $error("col_valid exp %0d got %0d", want.col_valid, out_if.col_valid);
          errors++;
        end
        if (out_if.row_valid !== want.row_valid) begin
          $error("row_valid exp %0d got %0d", want.row_valid, out_if.row_valid);
          errors++;
        end
        if (out_if.col_index !== want.col_index) begin
          $error("col_index exp %0d got %0d", want.col_index, out_if.col_index);
          errors++;
        end
        if (out_if.row_index !== want.row_index) begin
          $error("row_index exp %0d got %0d", want.row_index, out_if.row_index);
          errors++;
        end
        if (out_if.linear_index !== want.linear_index) begin
          $error("linear_index exp %0d got %0d", want.linear_index, out_if.linear_index);
          errors++;
        end
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off to back up the pipeline
  initial begin
    int hold;
    bit held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (!held && n_out >= 400) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      hold = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Write one register; the enable stays up, the caller drops it after the last write
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SHAPE:    grid_shape = data[0];
      CFG_ORIGIN_X: grid_ox    = data;
      CFG_ORIGIN_Y: grid_oy    = data;
      CFG_TILE_W:   grid_tw    = data[23:0];
      CFG_TILE_H:   grid_th    = data[23:0];
      CFG_COLUMNS:  grid_nc    = data[10:0];
      CFG_ROWS:     grid_nr    = data[10:0];
      default: ;
    endcase
  endtask

  // Offer one query and hold it until taken; a gap may follow
  task automatic offer(logic op, logic [31:0] x, logic [31:0] y, logic typed, res_t res);
    int gap;
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.pos_x   <= x;
    in_if.pos_y   <= y;
    cur_typed     <= typed;
    cur_typed_res <= res;
    do @(posedge clk_i); while (!in_if.ready);
    gap = idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (tile_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // Position near the grid, at an interesting point of a cell or at a random offset in it
  function automatic logic [31:0] near_grid(logic [31:0] org, logic [23:0] t, logic [10:0] n);
    longint tt, k, fr;
    tt = t == 0 ? 1 : longint'(t);
    k  = longint'($urandom_range(0, axis_count(n) + 3)) - 2;
    case ($urandom_range(0, 5))
      0: fr = 0;
      1: fr = tt / 2;
      2: fr = tt - 1;
      default: fr = longint'($urandom) % tt;
    endcase
    return 32'(longint'($signed(org)) + k * tt + fr);
  endfunction

  function automatic logic [23:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(1, 8));
      1: return 24'($urandom);
      default: return 24'($urandom_range(16, 2048));
    endcase
  endfunction

  function automatic logic [10:0] pick_count();
    case ($urandom_range(0, 5))
      0: return 11'($urandom);
      1: return 11'd1;
      default: return 11'($urandom_range(2, 40));
    endcase
  endfunction

  initial begin
    logic [31:0] ox, oy;
    logic [23:0] tw, th;
    logic [10:0] nc, nr;
    logic [31:0] x, y;
    in_if.valid <= 1'b0;
    in_if.op    <= OP_STRICT;
    in_if.pos_x <= '0;
    in_if.pos_y <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i])
      offer(probes[i].op, probes[i].x, probes[i].y, probes[i].typed, probes[i].res);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      ox = $urandom_range(0, 1) ? 32'($urandom_range(0, 8000)) - 32'd4000 : $urandom;
      oy = $urandom_range(0, 1) ? 32'($urandom_range(0, 8000)) - 32'd4000 : $urandom;
      tw = pick_size();
      th = pick_size();
      nc = pick_count();
      nr = pick_count();
      case (p)
        1: begin tw = 24'd0; th = 24'd0; end
        2: begin tw = 24'hFF_FFFF; th = 24'hFF_FFFF; end
        3: begin nc = 11'd0; nr = 11'd0; end
        4: begin nc = 11'd2047; nr = 11'd2047; end
        5: begin nc = 11'd1024; nr = 11'd1024; tw = 24'd1; th = 24'd1; end
        6: begin ox = 32'h7FFF_FFFF; oy = 32'h8000_0000; end
        7: begin ox = 32'h8000_0000; oy = 32'h7FFF_FFFF; end
        default: ;
      endcase
      write_reg(CFG_SHAPE, {$urandom_range(0, 1) ? $urandom : 32'd0} & ~32'd1 | 32'(p % 2));
      write_reg(CFG_ORIGIN_X, ox);
      write_reg(CFG_ORIGIN_Y, oy);
      write_reg(CFG_TILE_W, {8'($urandom), tw});
      write_reg(CFG_TILE_H, {8'($urandom), th});
      write_reg(CFG_COLUMNS, {21'($urandom), nc});
      write_reg(CFG_ROWS, {21'($urandom), nr});
      write_reg(CFG_SPARE, $urandom);
      cfg_we_i <= 1'b0;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          x = $urandom;
          y = $urandom;
        end else begin
          x = near_grid(grid_ox, grid_tw, grid_nc);
          y = near_grid(grid_oy, grid_th, grid_nr);
        end
        offer(logic'($urandom_range(0, 1)), x, y, 1'b0, '0);
      end
      drain();
    end

    $display("covered %0d queries over %0d grid settings, %0d of them on rhombus grids",
             n_in, PHASES + 1, n_rhom);
    if (errors == 0) begin
      $display("tile_grid_position_to_index_core regression: pass");
    end else begin
      $display("tile_grid_position_to_index_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("tile_grid_position_to_index_core regression: fail");
    $finish;
  end

endmodule
